### hdl/adpcm_pkg.sv
package adpcm_pkg;

  localparam int unsigned AddrW = 3;

  // header phases
  localparam logic [2:0] PH_IGNORE = 3'd0;
  localparam logic [2:0] PH_SHIFT  = 3'd1;
  localparam logic [2:0] PH_LO_A   = 3'd2;
  localparam logic [2:0] PH_HI_A   = 3'd3;
  localparam logic [2:0] PH_LO_B   = 3'd4;
  localparam logic [2:0] PH_HI_B   = 3'd5;
  localparam logic [2:0] PH_DATA   = 3'd6;

  localparam logic [7:0] CMD_REPEAT = 8'h80;
  localparam logic [7:0] CMD_UP     = 8'h81;
  localparam logic [7:0] CMD_SKIP   = 8'h82;

  localparam logic [6:0] IDX_START = 7'd44;
  localparam logic [6:0] IDX_MAX   = 7'd88;
  localparam logic [6:0] IDX_JUMP  = 7'd8;

  localparam logic [AddrW-1:2] REG_STEREO = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } core_res_t;

  function automatic logic signed [4:0] idx_adjust(input logic [4:0] code);
    logic signed [4:0] r;
    r = -5'sd1;
    if (code[0]) begin
      case (code[4:1])
        4'd0:    r = 5'sd0;
        4'd1:    r = 5'sd4;
        4'd2:    r = 5'sd2;
        4'd3:    r = 5'sd6;
        4'd4:    r = 5'sd1;
        4'd5:    r = 5'sd5;
        4'd6:    r = 5'sd3;
        4'd7:    r = 5'sd7;
        4'd8:    r = 5'sd1;
        4'd9:    r = 5'sd5;
        4'd10:   r = 5'sd3;
        4'd11:   r = 5'sd7;
        4'd12:   r = 5'sd2;
        4'd13:   r = 5'sd4;
        4'd14:   r = 5'sd6;
        default: r = 5'sd8;
      endcase
    end
    return r;
  endfunction

  // indices above the top of the table (87) read as 15'h7fff, not as the last entry
  function automatic logic [14:0] step_of(input logic [6:0] idx);
    logic [14:0] r;
    case (idx)
      7'd0:  r = 15'h0007;  7'd1:  r = 15'h0008;  7'd2:  r = 15'h0009;
      7'd3:  r = 15'h000a;  7'd4:  r = 15'h000b;  7'd5:  r = 15'h000c;
      7'd6:  r = 15'h000d;  7'd7:  r = 15'h000e;  7'd8:  r = 15'h0010;
      7'd9:  r = 15'h0011;  7'd10: r = 15'h0013;  7'd11: r = 15'h0015;
      7'd12: r = 15'h0017;  7'd13: r = 15'h0019;  7'd14: r = 15'h001c;
      7'd15: r = 15'h001f;  7'd16: r = 15'h0022;  7'd17: r = 15'h0025;
      7'd18: r = 15'h0029;  7'd19: r = 15'h002d;  7'd20: r = 15'h0032;
      7'd21: r = 15'h0037;  7'd22: r = 15'h003c;  7'd23: r = 15'h0042;
      7'd24: r = 15'h0049;  7'd25: r = 15'h0050;  7'd26: r = 15'h0058;
      7'd27: r = 15'h0061;  7'd28: r = 15'h006b;  7'd29: r = 15'h0076;
      7'd30: r = 15'h0082;  7'd31: r = 15'h008f;  7'd32: r = 15'h009d;
      7'd33: r = 15'h00ad;  7'd34: r = 15'h00be;  7'd35: r = 15'h00d1;
      7'd36: r = 15'h00e6;  7'd37: r = 15'h00fd;  7'd38: r = 15'h0117;
      7'd39: r = 15'h0133;  7'd40: r = 15'h0151;  7'd41: r = 15'h0173;
      7'd42: r = 15'h0198;  7'd43: r = 15'h01c1;  7'd44: r = 15'h01ee;
      7'd45: r = 15'h0220;  7'd46: r = 15'h0256;  7'd47: r = 15'h0292;
      7'd48: r = 15'h02d4;  7'd49: r = 15'h031c;  7'd50: r = 15'h036c;
      7'd51: r = 15'h03c3;  7'd52: r = 15'h0424;  7'd53: r = 15'h048e;
      7'd54: r = 15'h0502;  7'd55: r = 15'h0583;  7'd56: r = 15'h0610;
      7'd57: r = 15'h06ab;  7'd58: r = 15'h0756;  7'd59: r = 15'h0812;
      7'd60: r = 15'h08e0;  7'd61: r = 15'h09c3;  7'd62: r = 15'h0abd;
      7'd63: r = 15'h0bd0;  7'd64: r = 15'h0cff;  7'd65: r = 15'h0e4c;
      7'd66: r = 15'h0fba;  7'd67: r = 15'h114c;  7'd68: r = 15'h1307;
      7'd69: r = 15'h14ee;  7'd70: r = 15'h1706;  7'd71: r = 15'h1954;
      7'd72: r = 15'h1bdc;  7'd73: r = 15'h1ea5;  7'd74: r = 15'h21b6;
      7'd75: r = 15'h2515;  7'd76: r = 15'h28ca;  7'd77: r = 15'h2cdf;
      7'd78: r = 15'h315b;  7'd79: r = 15'h364b;  7'd80: r = 15'h3bb9;
      7'd81: r = 15'h41b2;  7'd82: r = 15'h4844;  7'd83: r = 15'h4f7e;
      7'd84: r = 15'h5771;  7'd85: r = 15'h602f;  7'd86: r = 15'h69ce;
      7'd87: r = 15'h7462;
      default: r = 15'h7fff;
    endcase
    return r;
  endfunction

endpackage

### hdl/adpcm_cfg.sv
module adpcm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adpcm_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic                          stereo
);
  import adpcm_pkg::*;

  logic sel_stereo;

  assign sel_stereo = (paddr[AddrW-1:2] == REG_STEREO);
  assign pready     = 1'b1;
  assign prdata     = sel_stereo ? {31'd0, stereo} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo <= 1'b0;
    end else if (psel && penable && pwrite && pready && sel_stereo) begin
      stereo <= pwdata[0];
    end
  end

endmodule

### hdl/adpcm_core.sv
module adpcm_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  stereo,
  input  adpcm_pkg::in_item_t   item,
  output adpcm_pkg::core_res_t  res
);
  import adpcm_pkg::*;

  logic [2:0]         header_phase, header_phase_next;
  logic [7:0]         shift_amount, shift_amount_next;
  logic [7:0]         low_byte_hold, low_byte_hold_next;
  logic [6:0]         step_index [2];
  logic [6:0]         step_index_next [2];
  logic signed [15:0] last_sample [2];
  logic signed [15:0] last_sample_next [2];
  logic               current_channel, current_channel_next;

  // state as seen by this byte, after an optional stream restart
  logic [2:0]         ph_e;
  logic [7:0]         shift_e;
  logic [7:0]         low_e;
  logic [6:0]         idx_e [2];
  logic signed [15:0] last_e [2];
  logic               cur_e;

  logic [7:0]         b;
  logic               ch;
  logic [6:0]         idx_sel;
  logic [14:0]        step;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [15:0] s_new;
  logic signed [7:0]  idx_tmp;
  logic               first_of_two;

  always_comb begin
    b       = item.data_byte;
    ph_e    = item.stream_start ? PH_IGNORE : header_phase;
    shift_e = item.stream_start ? 8'd0 : shift_amount;
    low_e   = item.stream_start ? 8'd0 : low_byte_hold;
    cur_e   = item.stream_start ? 1'b1 : current_channel;
    for (int i = 0; i < 2; i++) begin
      idx_e[i]  = item.stream_start ? IDX_START : step_index[i];
      last_e[i] = item.stream_start ? 16'sd0 : last_sample[i];
    end

    header_phase_next    = ph_e;
    shift_amount_next    = shift_e;
    low_byte_hold_next   = low_e;
    current_channel_next = cur_e;
    step_index_next      = idx_e;
    last_sample_next     = last_e;

    res.emit         = 1'b0;
    res.item.sample  = 16'sd0;
    res.item.channel = 1'b0;

    first_of_two = (ph_e == PH_HI_A) && stereo;
    ch           = stereo ? ~cur_e : 1'b0;
    idx_sel      = idx_e[ch];

    // shift-add of up to seven terms (the shifted base term plus six) for a data byte
    step = step_of(idx_sel);
    diff = (shift_e < 8'd16) ? {2'b00, step >> shift_e[3:0]} : 17'd0;
    for (int i = 0; i < 6; i++) begin
      if (b[i]) begin
        diff = diff + {2'b00, step >> i};
      end
    end
    if (b[6]) begin
      sum   = {{2{last_e[ch][15]}}, last_e[ch]} - $signed({1'b0, diff});
      s_new = (sum < -18'sd32768) ? -16'sd32768 : sum[15:0];
    end else begin
      sum   = {{2{last_e[ch][15]}}, last_e[ch]} + $signed({1'b0, diff});
      s_new = (sum > 18'sd32767) ? 16'sd32767 : sum[15:0];
    end
    idx_tmp = $signed({1'b0, idx_sel}) + 8'(idx_adjust(b[4:0]));

    case (ph_e)
      PH_IGNORE: begin
        header_phase_next = PH_SHIFT;
      end
      PH_SHIFT: begin
        shift_amount_next = b;
        header_phase_next = PH_LO_A;
      end
      PH_LO_A, PH_LO_B: begin
        low_byte_hold_next = b;
        header_phase_next  = ph_e + 3'd1;
      end
      PH_HI_A, PH_HI_B: begin
        last_sample_next[first_of_two] = {b, low_e};
        step_index_next[first_of_two]  = IDX_START;
        header_phase_next = first_of_two ? PH_LO_B : PH_DATA;
        res.emit          = 1'b1;
        res.item.sample   = {b, low_e};
        res.item.channel  = first_of_two;
      end
      default: begin
        header_phase_next = PH_DATA;
        if (b[7]) begin
          if (b == CMD_SKIP) begin
            current_channel_next = stereo ? ch : cur_e;
          end else if (b == CMD_REPEAT) begin
            current_channel_next = stereo ? ch : cur_e;
            if (idx_sel != 7'd0) begin
              step_index_next[ch] = idx_sel - 7'd1;
            end
            res.emit         = 1'b1;
            res.item.sample  = last_e[ch];
            res.item.channel = ch;
          end else if (b == CMD_UP) begin
            step_index_next[ch] = (idx_sel > IDX_MAX - IDX_JUMP) ? IDX_MAX
                                                                  : idx_sel + IDX_JUMP;
          end else begin
            step_index_next[ch] = (idx_sel < IDX_JUMP) ? 7'd0 : idx_sel - IDX_JUMP;
          end
        end else begin
          current_channel_next = stereo ? ch : cur_e;
          last_sample_next[ch] = s_new;
          if (idx_tmp < 8'sd0) begin
            step_index_next[ch] = 7'd0;
          end else if (idx_tmp > $signed({1'b0, IDX_MAX})) begin
            step_index_next[ch] = IDX_MAX;
          end else begin
            step_index_next[ch] = idx_tmp[6:0];
          end
          res.emit         = 1'b1;
          res.item.sample  = s_new;
          res.item.channel = ch;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_phase    <= PH_IGNORE;
      shift_amount    <= 8'd0;
      low_byte_hold   <= 8'd0;
      current_channel <= 1'b1;
      for (int i = 0; i < 2; i++) begin
        step_index[i]  <= IDX_START;
        last_sample[i] <= 16'sd0;
      end
    end else if (fire) begin
      header_phase    <= header_phase_next;
      shift_amount    <= shift_amount_next;
      low_byte_hold   <= low_byte_hold_next;
      current_channel <= current_channel_next;
      step_index      <= step_index_next;
      last_sample     <= last_sample_next;
    end
  end

endmodule

### hdl/adpcm_stream_decoder.sv
// a byte accepted into the input register is decoded once the output register is free,
// and its sample is written to the output register, which holds it until pcm_ready
// throughput: one byte per cycle while pcm_ready does not stall the output register; set by the single decode pass
// between the input register and the output register, with state updated in place
// bytes that produce no sample (header, index jumps, skip) still take a decode pass and wait for a free output register
// synchronous active-high reset: stereo off, decoder state set to its start values, both registers empty
module adpcm_stream_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adpcm_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         byte_valid,
  output logic                         byte_ready,
  input  adpcm_pkg::in_item_t          byte_item,
  output logic                         pcm_valid,
  input  logic                         pcm_ready,
  output adpcm_pkg::out_item_t         pcm_item
);
  import adpcm_pkg::*;

  logic      stereo;
  logic      s1_valid;
  in_item_t  s1_item;
  core_res_t res;
  logic      out_free;
  logic      adv;

  adpcm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stereo  (stereo)
  );

  adpcm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (adv),
    .stereo (stereo),
    .item   (s1_item),
    .res    (res)
  );

  // output register is free when empty or being drained this cycle
  assign out_free   = !pcm_valid || pcm_ready;
  assign adv        = s1_valid && out_free;
  assign byte_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pcm_valid <= 1'b0;
    end else begin
      if (byte_ready) begin
        s1_valid <= byte_valid;
      end
      if (out_free) begin
        pcm_valid <= adv && res.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      s1_item <= byte_item;
    end
    if (adv && res.emit) begin
      pcm_item <= res.item;
    end
  end

endmodule
